// ===== src/pvve_pkg.sv =====
package pvve_pkg;

	// value type codes carried on the operation field
	typedef enum logic [3:0] {
		OP_BOOL    = 4'd0,
		OP_INT8    = 4'd1,
		OP_UINT8   = 4'd2,
		OP_UINT16  = 4'd3,
		OP_INT16   = 4'd4,
		OP_UINT32  = 4'd5,
		OP_INT32   = 4'd6,
		OP_UINT64  = 4'd7,
		OP_INT64   = 4'd8,
		OP_FLOAT32 = 4'd9,
		OP_FLOAT64 = 4'd10
	} op_t;

	localparam int unsigned MAX_EXTRA = 8;

	// leading-ones tag of the prefix byte for a given extra byte count
	function automatic logic [7:0] prefix_tag(input logic [3:0] extra);
		logic [7:0] tag;
		case (extra)
			4'd0:    tag = 8'h00;
			4'd1:    tag = 8'h80;
			4'd2:    tag = 8'hc0;
			4'd3:    tag = 8'he0;
			4'd4:    tag = 8'hf0;
			4'd5:    tag = 8'hf8;
			4'd6:    tag = 8'hfc;
			4'd7:    tag = 8'hfe;
			default: tag = 8'hff;
		endcase
		return tag;
	endfunction

	// number of extra bytes: one more for each 7-bit group boundary crossed
	function automatic logic [3:0] extra_bytes(input logic [63:0] v);
		logic [3:0] cnt;
		cnt = 4'd0;
		if (|v[63:7])  cnt = cnt + 4'd1;
		if (|v[63:14]) cnt = cnt + 4'd1;
		if (|v[63:21]) cnt = cnt + 4'd1;
		if (|v[63:28]) cnt = cnt + 4'd1;
		if (|v[63:35]) cnt = cnt + 4'd1;
		if (|v[63:42]) cnt = cnt + 4'd1;
		if (|v[63:49]) cnt = cnt + 4'd1;
		if (|v[63:56]) cnt = cnt + 4'd1;
		return cnt;
	endfunction

endpackage

// ===== src/prefix_varint_value_encoder_core.sv =====
// an accepted item passes the input stage and the serializer stage; its bytes leave from the output register
// throughput: one byte per cycle on the result side while an item is sent; an item has
// 1 to 9 bytes, set by its encoded length (prefix byte plus up to eight extra bytes)
// a new item moves on to the serializer while the previous one sends its last byte
// reset clears the input, serializer and strobe valid flags; the receiver cannot stall
module prefix_varint_value_encoder_core
	import pvve_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [3:0]  operation,
	input  logic [63:0] value,
	output logic        strobe,
	output logic [7:0]  out_byte,
	output logic        last
);

	logic        valid_s1;
	logic [3:0]  op_s1;
	logic [63:0] value_s1;

	logic        valid_s2;
	logic [63:0] enc_s2;
	logic [3:0]  extra_s2;
	logic [3:0]  idx_s2;

	logic        strobe_q;
	logic [7:0]  byte_q;
	logic        last_q;

	logic        accept;
	logic        s2_done;
	logic        s2_free;
	logic        load;

	logic        enc_ok;
	logic [63:0] enc_val;
	logic [3:0]  enc_extra;
	logic [15:0] zz16;
	logic [31:0] zz32;
	logic [63:0] zz64;

	logic [3:0]  shift_bytes;
	logic [63:0] shifted;
	logic [7:0]  cur_byte;

	// handshake and stage hand-off
	assign s2_done = valid_s2 && (idx_s2 == extra_s2);
	assign s2_free = !valid_s2 || s2_done;
	assign load    = valid_s1 && s2_free;
	assign busy    = valid_s1 && !s2_free;
	assign accept  = start && !busy;

	// zigzag mapping within the 16, 32 and 64-bit signed widths
	assign zz16 = {value_s1[14:0], 1'b0} ^ {16{value_s1[15]}};
	assign zz32 = {value_s1[30:0], 1'b0} ^ {32{value_s1[31]}};
	assign zz64 = {value_s1[62:0], 1'b0} ^ {64{value_s1[63]}};

	// map the typed value to the unsigned word to serialize
	always_comb begin
		enc_ok  = 1'b1;
		enc_val = 64'd0;
		unique case (op_s1) inside
			OP_BOOL:    enc_val = {63'd0, |value_s1};
			OP_INT8,
			OP_UINT8:   enc_val = {56'd0, value_s1[7:0]};
			OP_UINT16:  enc_val = {48'd0, value_s1[15:0]};
			OP_INT16:   enc_val = {48'd0, zz16};
			OP_UINT32:  enc_val = {32'd0, value_s1[31:0]};
			OP_INT32:   enc_val = {32'd0, zz32};
			OP_UINT64:  enc_val = value_s1;
			OP_INT64:   enc_val = zz64;
			OP_FLOAT32: enc_val = {32'd0, value_s1[7:0], value_s1[15:8],
				value_s1[23:16], value_s1[31:24]};
			OP_FLOAT64: enc_val = {value_s1[7:0], value_s1[15:8], value_s1[23:16],
				value_s1[31:24], value_s1[39:32], value_s1[47:40],
				value_s1[55:48], value_s1[63:56]};
			default:    enc_ok = 1'b0;
		endcase
	end

	// single raw bytes never take a prefix
	assign enc_extra = (op_s1 == OP_INT8 || op_s1 == OP_UINT8) ? 4'd0
		: extra_bytes(enc_val);

	// current byte: prefix byte carries the tag over the top bits
	assign shift_bytes = extra_s2 - idx_s2;
	assign shifted     = enc_s2 >> {shift_bytes, 3'b000};
	assign cur_byte    = shifted[7:0] | ((idx_s2 == 4'd0) ? prefix_tag(extra_s2) : 8'h00);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (load) begin
				valid_s1 <= 1'b0;
			end
			if (load) begin
				valid_s2 <= enc_ok;
			end else if (s2_done) begin
				valid_s2 <= 1'b0;
			end
			strobe_q <= valid_s2;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= operation;
			value_s1 <= value;
		end
		if (load) begin
			enc_s2   <= enc_val;
			extra_s2 <= enc_extra;
			idx_s2   <= 4'd0;
		end else if (valid_s2) begin
			idx_s2 <= idx_s2 + 4'd1;
		end
		byte_q <= cur_byte;
		last_q <= s2_done;
	end

	// result beat outputs
	assign strobe   = strobe_q;
	assign out_byte = byte_q;
	assign last     = last_q;

endmodule

// ===== tb/prefix_varint_value_encoder_core_check.sv =====
`timescale 1ns / 1ps

module prefix_varint_value_encoder_core_check
	import pvve_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [3:0]  operation,
	input  logic [63:0] value,
	input  logic        strobe,
	input  logic [7:0]  out_byte,
	input  logic        last,
	output int unsigned mismatches,
	output int unsigned bytes_pending
);

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} enc_byte_t;

	// serialized bytes still owed by the block, oldest first
	enc_byte_t expected_bytes[$];

	initial begin
		mismatches = 0;
		bytes_pending = 0;
	end

	function automatic void push_byte(input logic [7:0] data, input logic is_last);
		enc_byte_t b;
		b.data = data;
		b.last = is_last;
		expected_bytes.push_back(b);
	endfunction

	// prefix byte with k leading ones, then k bytes msb first
	function automatic void push_varint(input logic [63:0] v);
		int unsigned extra;
		logic [63:0] top;
		logic [15:0] tag;
		extra = 0;
		top = v;
		while (extra < MAX_EXTRA && top > (64'h7f >> extra)) begin
			top = top >> 8;
			extra++;
		end
		tag = 16'hff << (8 - extra);
		push_byte(top[7:0] | tag[7:0], extra == 0);
		for (int i = int'(extra); i > 0; i--)
			push_byte(8'(v >> (8 * (i - 1))), i == 1);
	endfunction

	// shift left in the width, invert the width when negative
	function automatic logic [63:0] zigzag_map(input logic [63:0] v, input int unsigned width);
		logic [63:0] mask;
		logic [63:0] u;
		mask = (width == 64) ? '1 : ((64'd1 << width) - 64'd1);
		u = (v << 1) & mask;
		if (v[width - 1])
			u = ~u & mask;
		return u;
	endfunction

	function automatic logic [63:0] swap_order(input logic [63:0] v, input int unsigned nbytes);
		logic [63:0] r;
		r = '0;
		for (int i = 0; i < nbytes; i++)
			r = (r << 8) | {56'd0, v[8 * i +: 8]};
		return r;
	endfunction

	// expected bytes of one typed value
	function automatic void predict_encoding(input logic [3:0] op, input logic [63:0] v);
		case (op) inside
			OP_BOOL:              push_byte({7'd0, |v}, 1'b1);
			OP_INT8, OP_UINT8:    push_byte(v[7:0], 1'b1);
			OP_UINT16:            push_varint({48'd0, v[15:0]});
			OP_INT16:             push_varint(zigzag_map({48'd0, v[15:0]}, 16));
			OP_UINT32:            push_varint({32'd0, v[31:0]});
			OP_INT32:             push_varint(zigzag_map({32'd0, v[31:0]}, 32));
			OP_UINT64:            push_varint(v);
			OP_INT64:             push_varint(zigzag_map(v, 64));
			OP_FLOAT32:           push_varint(swap_order({32'd0, v[31:0]}, 4));
			OP_FLOAT64:           push_varint(swap_order(v, 8));
			default: ;
		endcase
	endfunction

	// compare output beats first, then record the new item
	always @(posedge clk) begin : watch
		enc_byte_t want;
		if (arst_n) begin
			if (strobe) begin
				if (expected_bytes.size() == 0) begin
					mismatches++;
					$display("%0t: out_byte expected none actual %h last %b",
						$time, out_byte, last);
				end else begin
					want = expected_bytes.pop_front();
					if (out_byte !== want.data) begin
						mismatches++;
						$display("%0t: out_byte expected %h actual %h",
							$time, want.data, out_byte);
					end
					if (last !== want.last) begin
						mismatches++;
						$display("%0t: last expected %b actual %b", $time, want.last, last);
					end
				end
			end
			if (start && !busy)
				predict_encoding(operation, value);
		end
		bytes_pending <= expected_bytes.size();
	end

endmodule

// ===== tb/prefix_varint_value_encoder_core_test.sv =====
`timescale 1ns / 1ps

module prefix_varint_value_encoder_core_test;
	import pvve_pkg::*;

	localparam int unsigned IDLE_LIMIT    = 500;
	localparam int unsigned RANDOM_ITEMS  = 400;
	localparam int unsigned SETTLE_CYCLES = 16;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [3:0]  operation;
	logic [63:0] value;
	logic        strobe;
	logic [7:0]  out_byte;
	logic        last;
	int unsigned mismatches;
	int unsigned bytes_pending;
	int unsigned idle_cycles = 0;

	always #4 clk = ~clk;

	prefix_varint_value_encoder_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.operation (operation),
		.value     (value),
		.strobe    (strobe),
		.out_byte  (out_byte),
		.last      (last)
	);

	prefix_varint_value_encoder_core_check check (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.operation     (operation),
		.value         (value),
		.strobe        (strobe),
		.out_byte      (out_byte),
		.last          (last),
		.mismatches    (mismatches),
		.bytes_pending (bytes_pending)
	);

	// watchdog on cycles with no beat in or out
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// optional gap, then hold the item until the block takes it
	task automatic send_value(input logic [3:0] op, input logic [63:0] v,
		input int unsigned gap);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		operation <= op;
		value <= v;
		do @(posedge clk); while (busy);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (bytes_pending != 0);
	endtask

	initial begin : stimulus
		logic [3:0]  op;
		logic [63:0] word;
		int unsigned bit_pos;
		int unsigned gap;

		arst_n <= 1'b0;
		start <= 1'b0;
		operation <= OP_BOOL;
		value <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, every type, wide bool, ignored high bits
		send_value(OP_BOOL,    64'd0,                   $urandom_range(0, 8));
		send_value(OP_BOOL,    64'd1,                   $urandom_range(0, 8));
		send_value(OP_BOOL,    64'h8000_0000_0000_0000, $urandom_range(0, 8));
		send_value(OP_INT8,    64'h0000_0000_0000_00ff, $urandom_range(0, 8));
		send_value(OP_UINT8,   64'hffff_ffff_ffff_ff80, $urandom_range(0, 8));
		send_value(OP_UINT16,  64'h0000_0000_0000_007f, $urandom_range(0, 8));
		send_value(OP_UINT16,  64'h0000_0000_0000_0080, $urandom_range(0, 8));
		send_value(OP_UINT16,  64'hffff_ffff_ffff_ffff, $urandom_range(0, 8));
		send_value(OP_INT16,   64'h0000_0000_0000_ffff, 0);
		send_value(OP_INT16,   64'h0000_0000_0000_7fff, 0);
		send_value(OP_INT16,   64'hffff_ffff_ffff_8000, 0);
		send_value(OP_UINT32,  64'hffff_ffff_ffff_ffff, $urandom_range(0, 8));
		send_value(OP_INT32,   64'h0000_0000_8000_0000, $urandom_range(0, 8));
		send_value(OP_INT32,   64'h0000_0000_7fff_ffff, $urandom_range(0, 8));
		send_value(OP_UINT64,  64'hffff_ffff_ffff_ffff, 0);
		send_value(OP_UINT64,  64'h00ff_ffff_ffff_ffff, 0);
		send_value(OP_UINT64,  64'd0,                   0);
		send_value(OP_INT64,   64'h8000_0000_0000_0000, $urandom_range(0, 8));
		send_value(OP_INT64,   64'h7fff_ffff_ffff_ffff, $urandom_range(0, 8));
		send_value(OP_FLOAT32, 64'hffff_ffff_3f80_0000, $urandom_range(0, 8));
		send_value(OP_FLOAT64, 64'h3ff0_0000_0000_0000, $urandom_range(0, 8));
		send_value(4'(int'(OP_FLOAT64) + 1), 64'h1234_5678_9abc_def0, $urandom_range(0, 8));
		send_value(4'hf, 64'hffff_ffff_ffff_ffff, 0);
		send_value(OP_UINT64,  64'hffff_ffff_ffff_ffff, 0);

		// random types with values of every encoded length
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if ($urandom_range(0, 19) == 0)
				op = 4'($urandom_range(int'(OP_FLOAT64) + 1, 15));
			else
				op = 4'($urandom_range(int'(OP_BOOL), int'(OP_FLOAT64)));
			word = {$urandom, $urandom};
			case ($urandom_range(0, 3))
				0: ;
				1: word = word & (64'hffff_ffff_ffff_ffff >> $urandom_range(1, 63));
				2: word = ~(word >> $urandom_range(1, 63));
				default: begin
					bit_pos = $urandom_range(0, 63);
					word = (64'd1 << bit_pos) - 64'($urandom_range(0, 1));
				end
			endcase
			// hold off until the block has sent everything
			if (n == 150)
				drain_results();
			gap = (n >= 200 && n < 260) ? 0 : $urandom_range(0, 8);
			send_value(op, word, gap);
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
src/pvve_pkg.sv
src/prefix_varint_value_encoder_core.sv
tb/prefix_varint_value_encoder_core_check.sv
tb/prefix_varint_value_encoder_core_test.sv
